FILE: rtl/lofc_pkg.sv
// ----------------------------------------------------------------------------
// lofc_pkg
// Shared types, constants and the square-root table of the cell fusion block.
// ----------------------------------------------------------------------------
package lofc_pkg;

	localparam int unsigned MAP_CELLS_DEF = 16384;

	localparam logic [15:0] PROB_LOW  = 16'd13107;
	localparam logic [15:0] PROB_HIGH = 16'd52429;
	localparam logic [15:0] LN2_Q16   = 16'd45426;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	localparam logic [1:0] REG_OBS_GAIN  = 2'd0;
	localparam logic [1:0] REG_FLOOR     = 2'd1;
	localparam logic [1:0] REG_CEILING   = 2'd2;
	localparam logic [1:0] REG_THRESHOLD = 2'd3;

	typedef struct packed {
		logic        [15:0] obs_gain;
		logic signed [15:0] log_odds_floor;
		logic signed [15:0] log_odds_ceiling;
		logic        [15:0] traversable_threshold;
	} cfg_t;

	typedef logic [15:0][30:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_w;
		rem   = v;
		res   = '0;
		bit_w = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_w) begin
				rem = rem - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic root_tab_t build_roots();
		root_tab_t   tab;
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int i = 0; i < 16; i++) begin
			c = isqrt64(c << 30);
			tab[i] = c[30:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = build_roots();

endpackage

FILE: rtl/lofc_if.sv
// ----------------------------------------------------------------------------
// lofc_in_if / lofc_out_if
// Valid/ready channels for observation items and fused cell items.
// ----------------------------------------------------------------------------
interface lofc_in_if;
	logic        valid;
	logic        ready;
	logic [13:0] cell_index;
	logic [15:0] obs_prob;
	logic        observation_present;

	modport source (output valid, cell_index, obs_prob, observation_present,
		input ready);
	modport sink (input valid, cell_index, obs_prob, observation_present,
		output ready);
endinterface

interface lofc_out_if;
	logic               valid;
	logic               ready;
	logic        [13:0] updated_cell;
	logic signed [15:0] fused_log_odds;
	logic        [15:0] fused_prob;
	logic               traversable;

	modport source (output valid, updated_cell, fused_log_odds, fused_prob, traversable,
		input ready);
	modport sink (input valid, updated_cell, fused_log_odds, fused_prob, traversable,
		output ready);
endinterface

FILE: rtl/log_odds_cell_fusion_core.sv
// ----------------------------------------------------------------------------
// log_odds_cell_fusion_core
// Log-odds occupancy fusion: read a cell, add the weighted observation
// logit, clamp, write back and report the sigmoid probability; items with
// no observation or an out-of-range cell are taken and dropped. One item at
// a time: a new item is accepted once the last result enters the output
// register, paced by the 32 squaring steps of the log unit and the 16-step
// exp2 and 17-step divider of the sigmoid unit. Results leave through an
// output register. Reset restores the registers, then sweeps all MAP_CELLS
// cells writing zero into the cell store; no item is accepted during the sweep.
// ----------------------------------------------------------------------------
module log_odds_cell_fusion_core #(
	parameter int unsigned MAP_CELLS = lofc_pkg::MAP_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lofc_in_if.sink     in_ch,
	lofc_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lofc_pkg::*;

	localparam int AW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b00000001,
		S_IDLE   = 8'b00000010,
		S_LOG    = 8'b00000100,
		S_LOGIT  = 8'b00001000,
		S_WEIGHT = 8'b00010000,
		S_SUM    = 8'b00100000,
		S_SIG    = 8'b01000000,
		S_OUT    = 8'b10000000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic [15:0]  cell_mem [MAP_CELLS];
	logic [15:0]  rdata_q;
	logic [AW-1:0] clr_q;
	logic [13:0]  idx_q;
	logic         neg_q;
	logic [19:0]  mag_q;
	logic [13:0]  v_q;
	logic [14:0]  dmag_q;
	logic signed [15:0] sum_q;
	logic [15:0]  prob_q;

	logic         out_valid_q;
	logic [13:0]  out_cell_q;
	logic signed [15:0] out_lo_q;
	logic [15:0]  out_prob_q;
	logic         out_trav_q;

	logic         in_fire;
	logic [20:0]  idx_wide;
	logic         in_range;
	logic [15:0]  p_clamp;
	logic         log_start;
	logic         log_done;
	logic [19:0]  lp;
	logic [19:0]  lq;
	logic         sig_done;
	logic [15:0]  sig_prob;
	logic         sig_start;
	logic [35:0]  logit_prod;
	logic [29:0]  weight_prod;
	logic signed [17:0] sum_raw;
	logic signed [17:0] sum_lo;
	logic signed [17:0] sum_cl;
	logic         mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]  mem_wdata;
	logic [20:0]  idx_q_wide;
	logic         out_load;

	lofc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign idx_wide    = {7'd0, in_ch.cell_index};
	assign in_range    = idx_wide < 21'(MAP_CELLS);
	assign p_clamp     = (in_ch.obs_prob < PROB_LOW) ? PROB_LOW
		: (in_ch.obs_prob > PROB_HIGH) ? PROB_HIGH : in_ch.obs_prob;
	assign log_start   = in_fire && in_ch.observation_present && in_range;

	lofc_log2_unit u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.p      (p_clamp),
		.done   (log_done),
		.lp     (lp),
		.lq     (lq)
	);

	assign logit_prod  = 36'(mag_q) * 36'(LN2_Q16) + (36'd1 << 21);
	assign weight_prod = 30'(v_q) * 30'(cfg.obs_gain) + (30'd1 << 14);
	assign sum_raw     = 18'(signed'(rdata_q)) + (neg_q ? -18'(signed'({1'b0, dmag_q}))
		: 18'(signed'({1'b0, dmag_q})));
	assign sum_lo      = (sum_raw < 18'(cfg.log_odds_floor)) ? 18'(cfg.log_odds_floor)
		: sum_raw;
	assign sum_cl      = (sum_lo > 18'(cfg.log_odds_ceiling)) ? 18'(cfg.log_odds_ceiling)
		: sum_lo;
	assign sig_start   = (state_q == S_SUM);

	lofc_sigmoid_unit u_sig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sig_start),
		.x      (sum_cl[15:0]),
		.done   (sig_done),
		.prob   (sig_prob)
	);

	assign idx_q_wide = {7'd0, idx_q};
	assign mem_we     = (state_q == S_CLEAR) || (state_q == S_SUM);
	assign mem_waddr  = (state_q == S_CLEAR) ? clr_q : idx_q_wide[AW-1:0];
	assign mem_wdata  = (state_q == S_CLEAR) ? 16'd0 : sum_cl[15:0];

	always_ff @(posedge clk) begin
		if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
		if (log_start) rdata_q <= cell_mem[idx_wide[AW-1:0]];
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAP_CELLS - 1)) state_q <= S_IDLE;
				end
				S_IDLE:   if (log_start) state_q <= S_LOG;
				S_LOG:    if (log_done) state_q <= S_LOGIT;
				S_LOGIT:  state_q <= S_WEIGHT;
				S_WEIGHT: state_q <= S_SUM;
				S_SUM:    state_q <= S_SIG;
				S_SIG:    if (sig_done) state_q <= S_OUT;
				S_OUT:    if (out_load) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (log_start) idx_q <= in_ch.cell_index;
		if (state_q == S_LOG && log_done) begin
			neg_q <= lp < lq;
			mag_q <= (lp < lq) ? (lq - lp) : (lp - lq);
		end
		if (state_q == S_LOGIT) v_q <= logit_prod[35:22];
		if (state_q == S_WEIGHT) dmag_q <= weight_prod[29:15];
		if (state_q == S_SUM) sum_q <= sum_cl[15:0];
		if (state_q == S_SIG && sig_done) prob_q <= sig_prob;
		if (out_load) begin
			out_cell_q <= idx_q;
			out_lo_q   <= sum_q;
			out_prob_q <= prob_q;
			out_trav_q <= prob_q >= cfg.traversable_threshold;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.updated_cell   = out_cell_q;
	assign out_ch.fused_log_odds = out_lo_q;
	assign out_ch.fused_prob     = out_prob_q;
	assign out_ch.traversable    = out_trav_q;

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (cfg.log_odds_floor <= cfg.log_odds_ceiling) |->
		(out_ch.fused_log_odds >= cfg.log_odds_floor) &&
		(out_ch.fused_log_odds <= cfg.log_odds_ceiling))
		else $error("fused log-odds outside clamp bounds");

	a_trav: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.traversable == (out_ch.fused_prob >= cfg.traversable_threshold))
		else $error("traversable flag disagrees with threshold");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.fused_log_odds >= 0) == (out_ch.fused_prob >= 16'd32768))
		else $error("probability on wrong side of one half");

	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM |=> state_q == S_SIG && $past(mem_we))
		else $error("write-back missing for updated cell");
endmodule

FILE: rtl/lofc_apb_regs.sv
// ----------------------------------------------------------------------------
// lofc_apb_regs
// APB register file holding observation gain, clamp bounds and threshold.
// ----------------------------------------------------------------------------
module lofc_apb_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output lofc_pkg::cfg_t cfg
);
	import lofc_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obs_gain              <= 16'd32768;
			cfg_q.log_odds_floor        <= -16'sd2250;
			cfg_q.log_odds_ceiling      <= 16'sd2250;
			cfg_q.traversable_threshold <= 16'd32768;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				REG_OBS_GAIN:  cfg_q.obs_gain              <= pwdata[15:0];
				REG_FLOOR:     cfg_q.log_odds_floor        <= pwdata[15:0];
				REG_CEILING:   cfg_q.log_odds_ceiling      <= pwdata[15:0];
				REG_THRESHOLD: cfg_q.traversable_threshold <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_OBS_GAIN:  prdata = {16'd0, cfg_q.obs_gain};
			REG_FLOOR:     prdata = {16'd0, cfg_q.log_odds_floor};
			REG_CEILING:   prdata = {16'd0, cfg_q.log_odds_ceiling};
			REG_THRESHOLD: prdata = {16'd0, cfg_q.traversable_threshold};
			default:       prdata = '0;
		endcase
	end
endmodule

FILE: rtl/lofc_log2_unit.sv
// ----------------------------------------------------------------------------
// lofc_log2_unit
// Log2 of p and of 1-p in Q.16 by repeated squaring on one shared squarer.
// ----------------------------------------------------------------------------
module lofc_log2_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] p,
	output logic        done,
	output logic [19:0] lp,
	output logic [19:0] lq
);
	import lofc_pkg::*;

	typedef enum logic [1:0] {
		LG_IDLE = 2'b01,
		LG_RUN  = 2'b10
	} lg_state_t;

	lg_state_t   state_q;
	logic        phase_q;
	logic [3:0]  step_q;
	logic [3:0]  n_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [15:0] qx_q;
	logic [19:0] lp_q;
	logic [19:0] lq_q;
	logic        done_q;

	logic [61:0] sq;
	logic [31:0] ms;
	logic [30:0] m_nxt;
	logic [15:0] frac_nxt;
	logic [3:0]  qn;

	function automatic logic [3:0] msb16(input logic [15:0] x);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) n = 4'(i);
		end
		return n;
	endfunction

	assign sq       = 62'(m_q) * 62'(m_q);
	assign ms       = sq[61:30];
	assign m_nxt    = ms[31] ? ms[31:1] : ms[30:0];
	assign frac_nxt = frac_q | (ms[31] ? (16'd1 << (4'd15 - step_q)) : 16'd0);
	assign qn       = msb16(qx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				LG_IDLE: begin
					if (start) state_q <= LG_RUN;
				end
				LG_RUN: begin
					if (step_q == 4'd15 && phase_q) begin
						state_q <= LG_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= LG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == LG_IDLE && start) begin
			phase_q <= 1'b0;
			step_q  <= '0;
			n_q     <= msb16(p);
			m_q     <= 31'(p) << (5'd30 - 5'(msb16(p)));
			frac_q  <= '0;
			qx_q    <= 16'(17'h10000 - 17'(p));
		end else if (state_q == LG_RUN) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'd15) begin
				if (!phase_q) begin
					lp_q    <= {n_q, frac_nxt};
					phase_q <= 1'b1;
					n_q     <= qn;
					m_q     <= 31'(qx_q) << (5'd30 - 5'(qn));
					frac_q  <= '0;
				end else begin
					lq_q <= {n_q, frac_nxt};
				end
			end else begin
				m_q    <= m_nxt;
				frac_q <= frac_nxt;
			end
		end
	end

	assign done = done_q;
	assign lp   = lp_q;
	assign lq   = lq_q;
endmodule

FILE: rtl/lofc_sigmoid_unit.sv
// ----------------------------------------------------------------------------
// lofc_sigmoid_unit
// Sigmoid of Q5.10 log-odds to Q0.16: exp2 by root products, then divide.
// ----------------------------------------------------------------------------
module lofc_sigmoid_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] x,
	output logic               done,
	output logic        [15:0] prob
);
	import lofc_pkg::*;

	typedef enum logic [4:0] {
		SG_IDLE = 5'b00001,
		SG_T    = 5'b00010,
		SG_M    = 5'b00100,
		SG_D0   = 5'b01000,
		SG_DIV  = 5'b10000
	} sg_state_t;

	sg_state_t   state_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic [16:0] ax_q;
	logic [7:0]  k_q;
	logic [15:0] f_q;
	logic [30:0] m_q;
	logic [31:0] den_q;
	logic [32:0] r_q;
	logic [16:0] nlow_q;
	logic [16:0] quo_q;
	logic [15:0] prob_q;
	logic        done_q;

	logic signed [16:0] xe;
	logic [33:0] tprod;
	logic [23:0] t;
	logic [61:0] mprod;
	logic [30:0] ms;
	logic [31:0] den;
	logic [46:0] num;
	logic [46:0] nd;
	logic [32:0] r2;
	logic        ge;

	assign xe    = {x[15], x};
	assign tprod = 34'(ax_q) * 34'(LOG2E_Q16);
	assign t     = 24'((tprod + 34'd512) >> 10);
	assign mprod = 62'(m_q) * 62'(ROOT_TAB[cnt_q[3:0]]) + (62'd1 << 29);
	assign ms    = (k_q >= 8'd31) ? 31'd0 : (m_q >> k_q[4:0]);
	assign den   = (32'd1 << 30) + 32'(ms);
	assign num   = neg_q ? {ms, 16'd0} : (47'd1 << 46);
	assign nd    = num + 47'(den >> 1);
	assign r2    = {r_q[31:0], nlow_q[16]};
	assign ge    = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SG_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SG_IDLE: if (start) state_q <= SG_T;
				SG_T:    state_q <= SG_M;
				SG_M:    if (cnt_q == 5'd15) state_q <= SG_D0;
				SG_D0:   state_q <= SG_DIV;
				SG_DIV: begin
					if (cnt_q == 5'd16) begin
						state_q <= SG_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= SG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SG_IDLE: begin
				if (start) begin
					neg_q <= x[15];
					ax_q  <= x[15] ? 17'(-xe) : 17'(xe);
				end
			end
			SG_T: begin
				k_q   <= t[23:16];
				f_q   <= t[15:0];
				m_q   <= 31'd1 << 30;
				cnt_q <= '0;
			end
			SG_M: begin
				if (f_q[4'd15 - cnt_q[3:0]]) m_q <= mprod[60:30];
				cnt_q <= cnt_q + 5'd1;
			end
			SG_D0: begin
				den_q  <= den;
				r_q    <= 33'(nd[46:17]);
				nlow_q <= nd[16:0];
				quo_q  <= '0;
				cnt_q  <= '0;
			end
			SG_DIV: begin
				r_q    <= ge ? (r2 - {1'b0, den_q}) : r2;
				nlow_q <= {nlow_q[15:0], 1'b0};
				quo_q  <= {quo_q[15:0], ge};
				cnt_q  <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					prob_q <= ({quo_q[15:0], ge} > 17'd65535) ? 16'hFFFF
						: quo_q[14:0] * 16'd2 + 16'(ge);
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign prob = prob_q;
endmodule
